// ===== src/cia_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU package
// Shared widths, operation and status codes, and the pipeline word type.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam int W        = 64;
  localparam int HW       = W / 2;
  localparam int DivSteps = W;
  localparam int MulSteps = 3;
  localparam int Latency  = 1 + MulSteps + DivSteps + 1;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_MOD = 4'd4,
    OP_LT  = 4'd5,
    OP_LE  = 4'd6,
    OP_GT  = 4'd7,
    OP_GE  = 4'd8,
    OP_EQ  = 4'd9,
    OP_NE  = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIVZERO  = 2'd2,
    ST_NARROW   = 2'd3
  } status_t;

  typedef struct packed {
    logic         valid;
    logic [3:0]   op;
    logic         mode32;
    logic         check;
    logic         sa;
    logic         sb;
    logic         bzero;
    logic         min_m1;
    logic [W-1:0] res;
    logic         ovf;
    logic [W-1:0] mb;
    logic [W-1:0] rem;
    logic [W-1:0] q;
  } item_t;

  function automatic logic [W-1:0] sext32(input logic [W-1:0] x);
    sext32 = {{(W - HW){x[HW-1]}}, x[HW-1:0]};
  endfunction

endpackage

// ===== src/cia_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU channels
// Valid/ready channels for operation words and result words.
// ----------------------------------------------------------------------------
interface cia_in_if;
  logic                    valid;
  logic                    ready;
  logic [3:0]              operation;
  logic signed [63:0]      operand_a;
  logic signed [63:0]      operand_b;
  logic                    narrow_mode;
  logic                    narrow_check;
  modport source (output valid, operation, operand_a, operand_b, narrow_mode,
                  narrow_check, input ready);
  modport sink (input valid, operation, operand_a, operand_b, narrow_mode,
                narrow_check, output ready);
endinterface

interface cia_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink (input valid, result_value, status, output ready);
endinterface

// ===== src/cia_prep.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU operand stage
// Narrows operands, forms magnitudes, and resolves add, subtract and compare.
// ----------------------------------------------------------------------------
module cia_prep (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  valid,
  input  logic [3:0]            operation,
  input  logic [cia_pkg::W-1:0] operand_a,
  input  logic [cia_pkg::W-1:0] operand_b,
  input  logic                  narrow_mode,
  input  logic                  narrow_check,
  output cia_pkg::item_t        stage_o
);
  import cia_pkg::*;

  item_t        stage_r, stage_nxt;
  logic [W-1:0] a, b, sum, dif;

  always_comb begin
    a   = narrow_mode ? sext32(operand_a) : operand_a;
    b   = narrow_mode ? sext32(operand_b) : operand_b;
    sum = a + b;
    dif = a - b;
    stage_nxt        = '0;
    stage_nxt.valid  = valid;
    stage_nxt.op     = operation;
    stage_nxt.mode32 = narrow_mode;
    stage_nxt.check  = narrow_check;
    stage_nxt.sa     = a[W-1];
    stage_nxt.sb     = b[W-1];
    stage_nxt.bzero  = (b == '0);
    stage_nxt.min_m1 = narrow_mode && (a == sext32({{(W - HW){1'b0}}, 1'b1, {(HW - 1){1'b0}}}))
                       && (b == '1);
    stage_nxt.q      = a[W-1] ? (~a + 1'b1) : a;
    stage_nxt.mb     = b[W-1] ? (~b + 1'b1) : b;
    case (operation)
      OP_ADD: begin
        stage_nxt.res = sum;
        stage_nxt.ovf = (a[W-1] == b[W-1]) && (sum[W-1] != a[W-1]);
      end
      OP_SUB: begin
        stage_nxt.res = dif;
        stage_nxt.ovf = (a[W-1] != b[W-1]) && (dif[W-1] != a[W-1]);
      end
      OP_LT:   stage_nxt.res = {{(W - 1){1'b0}}, ($signed(a) < $signed(b))};
      OP_LE:   stage_nxt.res = {{(W - 1){1'b0}}, ($signed(a) <= $signed(b))};
      OP_GT:   stage_nxt.res = {{(W - 1){1'b0}}, ($signed(a) > $signed(b))};
      OP_GE:   stage_nxt.res = {{(W - 1){1'b0}}, ($signed(a) >= $signed(b))};
      OP_EQ:   stage_nxt.res = {{(W - 1){1'b0}}, (a == b)};
      OP_NE:   stage_nxt.res = {{(W - 1){1'b0}}, (a != b)};
      default: stage_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== src/cia_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU multiplier
// Three-stage magnitude multiplier built from four half-width products.
// ----------------------------------------------------------------------------
module cia_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cia_pkg::item_t stage_i,
  output cia_pkg::item_t stage_o
);
  import cia_pkg::*;

  item_t          s1_r, s2_r, s3_r, s3_nxt;
  logic [W-1:0]   ll_r, lh_r, hl_r, hh_r, ll2_r, hh2_r;
  logic [W:0]     mid_r;
  logic [2*W-1:0] full;

  always_comb begin
    full   = {hh2_r, ll2_r} + {{(W - HW - 1){1'b0}}, mid_r, {HW{1'b0}}};
    s3_nxt = s2_r;
    if (s2_r.op == OP_MUL) begin
      s3_nxt.res = full[W-1:0];
      s3_nxt.ovf = |full[2*W-1:W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
      s2_r.valid <= 1'b0;
      s3_r.valid <= 1'b0;
    end else if (en) begin
      s1_r  <= stage_i;
      ll_r  <= stage_i.q[HW-1:0] * stage_i.mb[HW-1:0];
      lh_r  <= stage_i.q[HW-1:0] * stage_i.mb[W-1:HW];
      hl_r  <= stage_i.q[W-1:HW] * stage_i.mb[HW-1:0];
      hh_r  <= stage_i.q[W-1:HW] * stage_i.mb[W-1:HW];
      s2_r  <= s1_r;
      ll2_r <= ll_r;
      hh2_r <= hh_r;
      mid_r <= {1'b0, lh_r} + {1'b0, hl_r};
      s3_r  <= s3_nxt;
    end
  end

  assign stage_o = s3_r;

endmodule

// ===== src/cia_div_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU divider step
// One restoring division step: one quotient bit per stage.
// ----------------------------------------------------------------------------
module cia_div_step (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cia_pkg::item_t stage_i,
  output cia_pkg::item_t stage_o
);
  import cia_pkg::*;

  item_t      stage_r, stage_nxt;
  logic [W:0] t, diff;
  logic       ge;

  always_comb begin
    t         = {stage_i.rem, stage_i.q[W-1]};
    diff      = t - {1'b0, stage_i.mb};
    ge        = (t >= {1'b0, stage_i.mb});
    stage_nxt = stage_i;
    stage_nxt.rem = ge ? diff[W-1:0] : t[W-1:0];
    stage_nxt.q   = {stage_i.q[W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign stage_o = stage_r;

endmodule

// ===== src/cia_final.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU result stage
// Applies signs, range checks and status priority, and holds the result word.
// ----------------------------------------------------------------------------
module cia_final (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  cia_pkg::item_t        stage_i,
  output logic                  valid_o,
  output logic [cia_pkg::W-1:0] result_o,
  output logic [1:0]            status_o
);
  import cia_pkg::*;

  localparam logic [W-1:0] Lim = {1'b1, {(W - 1){1'b0}}};

  logic         valid_r;
  logic [W-1:0] result_r, result_nxt, mag, r;
  logic [1:0]   status_r, status_nxt;
  logic         neg, use_sign, ovf, arith, divop;

  always_comb begin
    mag      = stage_i.res;
    neg      = 1'b0;
    use_sign = 1'b0;
    ovf      = stage_i.ovf;
    case (stage_i.op)
      OP_MUL: begin
        use_sign = 1'b1;
        neg      = stage_i.sa ^ stage_i.sb;
      end
      OP_DIV: begin
        use_sign = 1'b1;
        mag      = stage_i.q;
        neg      = stage_i.sa ^ stage_i.sb;
        ovf      = 1'b0;
      end
      OP_MOD: begin
        use_sign = 1'b1;
        mag      = stage_i.rem;
        neg      = stage_i.sa;
        ovf      = stage_i.min_m1;
      end
      default: ;
    endcase
    r = mag;
    if (use_sign) begin
      r = neg ? (~mag + 1'b1) : mag;
      if (neg ? (mag > Lim) : (mag >= Lim)) begin
        ovf = 1'b1;
      end
    end
    arith      = (stage_i.op <= OP_MOD);
    divop      = (stage_i.op == OP_DIV) || (stage_i.op == OP_MOD);
    status_nxt = ST_OK;
    if (arith) begin
      if (divop && stage_i.bzero) begin
        status_nxt = ST_DIVZERO;
      end else if (ovf || (stage_i.mode32 && (sext32(r) != r))) begin
        status_nxt = ST_OVERFLOW;
      end else if (!stage_i.mode32 && stage_i.check && (sext32(r) != r)) begin
        status_nxt = ST_NARROW;
      end
    end
    result_nxt = (status_nxt == ST_OK) ? r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r  <= stage_i.valid;
      result_r <= result_nxt;
      status_r <= status_nxt;
    end
  end

  assign valid_o  = valid_r;
  assign result_o = result_r;
  assign status_o = status_r;

endmodule

// ===== src/checked_integer_alu_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU
// Overflow-checked signed 64/32-bit ALU with a fully pipelined divider.
// ----------------------------------------------------------------------------
// The unit accepts one operation word every cycle and returns results in
// order. Every word passes from acceptance to its result through one
// operand stage, three multiplier stages, 64 restoring divider stages of one
// quotient bit each, and one result stage. All operations share this path.
// When the result word is not taken, the whole pipeline holds, and input
// ready follows from the output side in the same cycle.
module checked_integer_alu_unit (
  input logic         clk,
  input logic         rst_n,
  cia_in_if.sink      in_ch,
  cia_out_if.source   out_ch
);
  import cia_pkg::*;

  logic         adv;
  item_t        pipe [0:DivSteps + 1];
  logic [W-1:0] result;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  cia_prep u_prep (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (adv),
    .valid        (in_ch.valid),
    .operation    (in_ch.operation),
    .operand_a    (in_ch.operand_a),
    .operand_b    (in_ch.operand_b),
    .narrow_mode  (in_ch.narrow_mode),
    .narrow_check (in_ch.narrow_check),
    .stage_o      (pipe[0])
  );

  cia_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .stage_i (pipe[0]),
    .stage_o (pipe[1])
  );

  for (genvar i = 0; i < DivSteps; i++) begin : g_div
    cia_div_step u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .stage_i (pipe[i + 1]),
      .stage_o (pipe[i + 2])
    );
  end

  cia_final u_final (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .stage_i  (pipe[DivSteps + 1]),
    .valid_o  (out_ch.valid),
    .result_o (result),
    .status_o (out_ch.status)
  );

  assign out_ch.result_value = result;

  // A failed operation always reports a zero value.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.status != ST_OK) |-> (out_ch.result_value == '0))
    else $error("nonzero value with failing status");

  // A comparison leaving the divider yields only zero or one.
  a_cmp_bool: assert property (@(posedge clk) disable iff (!rst_n)
    pipe[DivSteps + 1].valid && (pipe[DivSteps + 1].op >= OP_LT)
    && (pipe[DivSteps + 1].op <= OP_NE) |-> (pipe[DivSteps + 1].res[W-1:1] == '0))
    else $error("comparison value out of range");

  // A stalled pipeline keeps the word at the divider's last stage.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(pipe[DivSteps + 1]))
    else $error("divider output changed during stall");

endmodule

// ===== verif/checked_integer_alu_unit_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU result checker
// Watches both channels, predicts each result word from the accepted
// operation word and compares it, in order, with the words the unit returns.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit_checker (
  input  logic clk,
  input  logic rst_n,
  cia_in_if.sink  in_mon,
  cia_out_if.sink out_mon,
  output int   fail_count,
  output int   pending_count,
  output int   result_count
);
  import cia_pkg::*;

  typedef struct {
    logic [63:0] value;
    status_t     st;
  } alu_result_t;

  alu_result_t expected_results[$];

  function automatic logic [63:0] mag64(input logic [63:0] x);
    mag64 = x[63] ? -x : x;
  endfunction

  function automatic logic [63:0] apply_sign(input logic [63:0] m, input logic neg,
                                             inout logic ovf);
    if (neg) begin
      if (m > 64'h8000_0000_0000_0000) ovf = 1'b1;
      apply_sign = -m;
    end else begin
      if (m >= 64'h8000_0000_0000_0000) ovf = 1'b1;
      apply_sign = m;
    end
  endfunction

  function automatic alu_result_t compute_alu(input logic [3:0] op,
                                              input logic [63:0] a_in,
                                              input logic [63:0] b_in,
                                              input logic m32, input logic chk);
    alu_result_t res;
    logic [63:0] a, b, r, ma, mb;
    logic [127:0] prod;
    logic ovf;
    status_t st;
    a = m32 ? {{32{a_in[31]}}, a_in[31:0]} : a_in;
    b = m32 ? {{32{b_in[31]}}, b_in[31:0]} : b_in;
    r = '0;
    ovf = 1'b0;
    st = ST_OK;
    ma = mag64(a);
    mb = mag64(b);
    case (op)
      OP_ADD: begin
        r = a + b;
        ovf = (a[63] == b[63]) && (r[63] != a[63]);
      end
      OP_SUB: begin
        r = a - b;
        ovf = (a[63] != b[63]) && (r[63] != a[63]);
      end
      OP_MUL: begin
        prod = ma * mb;
        if (prod[127:64] != 0) ovf = 1'b1;
        else r = apply_sign(prod[63:0], a[63] ^ b[63], ovf);
      end
      OP_DIV, OP_MOD: begin
        if (b == 0) st = ST_DIVZERO;
        else if (op == OP_DIV) r = apply_sign(ma / mb, a[63] ^ b[63], ovf);
        else begin
          r = apply_sign(ma % mb, a[63], ovf);
          if (m32 && a == 64'hFFFF_FFFF_8000_0000 && b == '1) ovf = 1'b1;
        end
      end
      OP_LT: r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      OP_LE: r = ($signed(a) <= $signed(b)) ? 64'd1 : 64'd0;
      OP_GT: r = ($signed(a) > $signed(b)) ? 64'd1 : 64'd0;
      OP_GE: r = ($signed(a) >= $signed(b)) ? 64'd1 : 64'd0;
      OP_EQ: r = (a == b) ? 64'd1 : 64'd0;
      OP_NE: r = (a != b) ? 64'd1 : 64'd0;
      default: r = '0;
    endcase
    if (st == ST_OK && op <= OP_MOD) begin
      if (ovf) st = ST_OVERFLOW;
      else if (r != {{32{r[31]}}, r[31:0]}) begin
        if (m32) st = ST_OVERFLOW;
        else if (chk) st = ST_NARROW;
      end
    end
    if (st != ST_OK) r = '0;
    res.value = r;
    res.st = st;
    return res;
  endfunction

  always @(posedge clk) begin
    alu_result_t exp_r;
    if (!rst_n) begin
      fail_count <= 0;
      result_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_results.push_back(compute_alu(in_mon.operation, in_mon.operand_a,
                                               in_mon.operand_b, in_mon.narrow_mode,
                                               in_mon.narrow_check));
      if (out_mon.valid && out_mon.ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("ERROR: result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_mon.result_value !== exp_r.value || out_mon.status !== exp_r.st) begin
            if (fail_count < 10)
              $display("ERROR: expected value %h status %0d, got value %h status %0d",
                       exp_r.value, exp_r.st, out_mon.result_value, out_mon.status);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign pending_count = expected_results.size();

endmodule

// ===== verif/checked_integer_alu_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Checked integer ALU testbench
// Drives directed corner cases and random operation words with random gaps
// and output stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module checked_integer_alu_unit_tb;
  import cia_pkg::*;

  localparam int RandomWords = 630;
  localparam int CycleLimit  = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count, pending_count, result_count;
  int   cycle_count = 0;
  int   word_count = 0;
  int   out_wait = 0;
  logic [63:0] corner_values[8] = '{64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
                                     64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 64'd1,
                                     64'hFFFF_FFFF_8000_0000, 64'h0000_0000_7FFF_FFFF,
                                     64'h0000_0000_8000_0000};

  cia_in_if  in_ch();
  cia_out_if out_ch();

  checked_integer_alu_unit dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  checked_integer_alu_unit_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.operation = '0;
    in_ch.operand_a = '0;
    in_ch.operand_b = '0;
    in_ch.narrow_mode = 1'b0;
    in_ch.narrow_check = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Timeout with %0d results outstanding", pending_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: after each taken word it may hold ready low at random, with long runs of no waiting.
  always @(posedge clk) begin : rx_pace
    int w;
    w = out_wait;
    if (rst_n && out_ch.valid && out_ch.ready)
      w = (cycle_count % 1000 < 300) ? 0 : int'($urandom_range(0, 3));
    else if (w > 0)
      w = w - 1;
    out_wait <= w;
    out_ch.ready <= rst_n && (w == 0);
  end

  function automatic logic [63:0] rand_operand();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0: v = corner_values[$urandom_range(0, 7)];
      1: v = 64'($signed($urandom_range(0, 20)) - 10);
      2: v = {{32{1'b0}}, 32'($urandom())};
      3: v = {{32{1'b1}}, 32'($urandom())};
      default: v = {32'($urandom()), 32'($urandom())};
    endcase
    return v;
  endfunction

  task automatic send_word(input logic [3:0] op, input logic [63:0] a, input logic [63:0] b,
                           input logic m32, input logic chk);
    int gap;
    gap = (word_count % 200 < 60) ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.operand_a <= a;
    in_ch.operand_b <= b;
    in_ch.narrow_mode <= m32;
    in_ch.narrow_check <= chk;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    word_count++;
  endtask

  initial begin
    logic [3:0] op;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_word(OP_ADD, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1, 1'b0, 1'b0);
    send_word(OP_SUB, 64'h8000_0000_0000_0000, 64'd1, 1'b0, 1'b0);
    send_word(OP_MUL, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_word(OP_MUL, 64'h0000_0001_0000_0000, 64'h0000_0001_0000_0000, 1'b0, 1'b0);
    send_word(OP_DIV, 64'd5, 64'd0, 1'b0, 1'b0);
    send_word(OP_MOD, 64'd5, 64'd0, 1'b1, 1'b0);
    send_word(OP_DIV, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_word(OP_DIV, 64'h0000_0000_8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);
    send_word(OP_MOD, 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0);
    send_word(OP_MOD, 64'h0000_0000_8000_0000, 64'h0000_0000_FFFF_FFFF, 1'b1, 1'b0);
    send_word(OP_DIV, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b0, 1'b0);
    send_word(OP_MOD, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2, 1'b0, 1'b0);
    send_word(OP_ADD, 64'h0000_0000_7FFF_FFFF, 64'd1, 1'b0, 1'b1);
    send_word(OP_ADD, 64'h1234_5678_7FFF_FFFF, 64'd1, 1'b1, 1'b1);
    send_word(OP_SUB, 64'h0, 64'h0000_0000_8000_0000, 1'b1, 1'b0);
    for (int k = OP_LT; k <= OP_NE; k++)
      send_word(4'(k), 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b1);
    send_word(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_word(4'd11, 64'd3, 64'd4, 1'b0, 1'b0);
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // The sender holds off here until the pipeline has drained completely.
    while (pending_count != 0) @(posedge clk);

    for (int n = 0; n < RandomWords; n++) begin
      op = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                        : 4'($urandom_range(0, 10));
      send_word(op, rand_operand(), rand_operand(), 1'($urandom()), 1'($urandom()));
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (pending_count != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    $display("Sent %0d operation words (all opcodes, both widths, corner operands);", word_count);
    $display("checked %0d result words under random gaps and output stalls.", result_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cia_pkg.sv
src/cia_if.sv
src/cia_prep.sv
src/cia_mul.sv
src/cia_div_step.sv
src/cia_final.sv
src/checked_integer_alu_unit.sv
verif/checked_integer_alu_unit_checker.sv
verif/checked_integer_alu_unit_tb.sv
